// ===== rtl/lhfs_pkg.sv =====
// ----------------------------------------------------------------------------
// lhfs_pkg: shared types and constants of the link-health fallback stepper
// Field widths, register codes, reset values, fixed class thresholds and the
// payload and control structs passed between the stepper's modules.
// ----------------------------------------------------------------------------
package lhfs_pkg;

   // field widths
   localparam int STAGE_W = 3;
   localparam int LOSS_W  = 10;
   localparam int CNT16_W = 16;
   localparam int TIME_W  = 40;
   localparam int RUN_W   = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // register map
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAX_STAGE      = 3'd0,
      CSR_START_STAGE    = 3'd1,
      CSR_EVAL_INTERVAL  = 3'd2,
      CSR_CHANGE_INTERVAL = 3'd3,
      CSR_ESCALATE       = 3'd4,
      CSR_RECOVER        = 3'd5,
      CSR_DEGRADE_LOSS   = 3'd6,
      CSR_HEALTHY_LOSS   = 3'd7
   } csr_index_type;

   // register reset values
   localparam logic [STAGE_W-1:0] RST_MAX_STAGE       = 3'd4;
   localparam logic [STAGE_W-1:0] RST_START_STAGE     = 3'd0;
   localparam logic [CNT16_W-1:0] RST_EVAL_INTERVAL   = 16'd1000;
   localparam logic [CNT16_W-1:0] RST_CHANGE_INTERVAL = 16'd5000;
   localparam logic [RUN_W-1:0]   RST_ESCALATE        = 8'd3;
   localparam logic [RUN_W-1:0]   RST_RECOVER         = 8'd15;
   localparam logic [LOSS_W-1:0]  RST_DEGRADE_LOSS    = 10'd180;
   localparam logic [LOSS_W-1:0]  RST_HEALTHY_LOSS    = 10'd50;

   // fixed window-class thresholds
   localparam logic [CNT16_W-1:0] DROP_DEGRADE_MIN  = 16'd2;
   localparam logic [CNT16_W-1:0] RETX_DEGRADE_MIN  = 16'd3;
   localparam logic [CNT16_W-1:0] VQ_DEGRADE_MIN    = 16'd32;
   localparam logic [CNT16_W-1:0] INFL_DEGRADE_MIN  = 16'd24;
   localparam logic [CNT16_W-1:0] RETX_HEALTHY_MAX  = 16'd1;
   localparam logic [CNT16_W-1:0] VQ_HEALTHY_MAX    = 16'd8;
   localparam logic [CNT16_W-1:0] INFL_HEALTHY_MAX  = 16'd6;

   localparam logic [RUN_W-1:0] RUN_SAT = 8'hFF;

   typedef struct packed {
      logic                sync_locked;
      logic [LOSS_W-1:0]   loss_tenths;
      logic [CNT16_W-1:0]  dropped_delta;
      logic [CNT16_W-1:0]  retransmit_delta;
      logic [CNT16_W-1:0]  video_queue_depth;
      logic [CNT16_W-1:0]  inflight_depth;
      logic [TIME_W-1:0]   now_ms;
   } req_item_type;

   typedef struct packed {
      logic               changed;
      logic [STAGE_W-1:0] current_stage;
      logic               evaluated;
   } rsp_item_type;

   // live register values
   typedef struct packed {
      logic [STAGE_W-1:0] max_stage;
      logic [CNT16_W-1:0] eval_interval_ms;
      logic [CNT16_W-1:0] change_interval_ms;
      logic [RUN_W-1:0]   escalate_windows;
      logic [RUN_W-1:0]   recover_windows;
      logic [LOSS_W-1:0]  degrade_loss_tenths;
      logic [LOSS_W-1:0]  healthy_loss_tenths;
   } cfg_type;

   // register writes that act on the stepper state
   typedef struct packed {
      logic               max_wr;
      logic [STAGE_W-1:0] max_val;
      logic               start_wr;
      logic [STAGE_W-1:0] start_val;
   } csr_evt_type;

   typedef struct packed {
      logic degraded;
      logic healthy;
   } class_type;

   function automatic logic [STAGE_W-1:0] stage_min(input logic [STAGE_W-1:0] a,
                                                    input logic [STAGE_W-1:0] b);
      stage_min = (a > b) ? b : a;
   endfunction

endpackage

// ===== rtl/lhfs_if.sv =====
// ----------------------------------------------------------------------------
// lhfs_if: request and response channels of the fallback stepper
// Valid/ready channels; a beat moves on a clock edge with valid and ready high.
// ----------------------------------------------------------------------------
interface lhfs_req_if;
   import lhfs_pkg::*;

   logic                valid;
   logic                ready;
   logic                sync_locked;
   logic [LOSS_W-1:0]   loss_tenths;
   logic [CNT16_W-1:0]  dropped_delta;
   logic [CNT16_W-1:0]  retransmit_delta;
   logic [CNT16_W-1:0]  video_queue_depth;
   logic [CNT16_W-1:0]  inflight_depth;
   logic [TIME_W-1:0]   now_ms;

   modport source (
      output valid, sync_locked, loss_tenths, dropped_delta, retransmit_delta,
             video_queue_depth, inflight_depth, now_ms,
      input  ready
   );
   modport sink (
      input  valid, sync_locked, loss_tenths, dropped_delta, retransmit_delta,
             video_queue_depth, inflight_depth, now_ms,
      output ready
   );
endinterface

interface lhfs_rsp_if;
   import lhfs_pkg::*;

   logic               valid;
   logic               ready;
   logic               changed;
   logic [STAGE_W-1:0] current_stage;
   logic               evaluated;

   modport source (
      output valid, changed, current_stage, evaluated,
      input  ready
   );
   modport sink (
      input  valid, changed, current_stage, evaluated,
      output ready
   );
endinterface

// ===== rtl/lhfs_csr.sv =====
// ----------------------------------------------------------------------------
// lhfs_csr: configuration registers
// Holds the threshold and interval registers; flags writes of max_stage and
// start_stage, which act directly on the stepper state.
// ----------------------------------------------------------------------------
module lhfs_csr #(
   parameter int STAGE_COUNT = 5
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [lhfs_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [lhfs_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output lhfs_pkg::cfg_type                   cfg,
   output lhfs_pkg::csr_evt_type               evt
);
   import lhfs_pkg::*;

   localparam logic [STAGE_W-1:0] STAGE_MAX = STAGE_W'(STAGE_COUNT - 1);
   localparam logic [STAGE_W-1:0] MAX_RESET = stage_min(RST_MAX_STAGE, STAGE_MAX);

   cfg_type       cfg_ff, cfg_in;
   csr_evt_type   evt_in;
   logic [STAGE_W-1:0] wr_stage;

   // register decode
   always_comb begin
      cfg_in   = cfg_ff;
      evt_in   = '0;
      wr_stage = stage_min(csr_wdata[STAGE_W-1:0], STAGE_MAX);
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_MAX_STAGE: begin
               cfg_in.max_stage = wr_stage;
               evt_in.max_wr    = 1'b1;
               evt_in.max_val   = wr_stage;
            end
            CSR_START_STAGE: begin
               evt_in.start_wr  = 1'b1;
               evt_in.start_val = stage_min(wr_stage, cfg_ff.max_stage);
            end
            CSR_EVAL_INTERVAL:   cfg_in.eval_interval_ms    = csr_wdata;
            CSR_CHANGE_INTERVAL: cfg_in.change_interval_ms  = csr_wdata;
            CSR_ESCALATE:        cfg_in.escalate_windows    = csr_wdata[RUN_W-1:0];
            CSR_RECOVER:         cfg_in.recover_windows     = csr_wdata[RUN_W-1:0];
            CSR_DEGRADE_LOSS:    cfg_in.degrade_loss_tenths = csr_wdata[LOSS_W-1:0];
            CSR_HEALTHY_LOSS:    cfg_in.healthy_loss_tenths = csr_wdata[LOSS_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_stage           <= MAX_RESET;
         cfg_ff.eval_interval_ms    <= RST_EVAL_INTERVAL;
         cfg_ff.change_interval_ms  <= RST_CHANGE_INTERVAL;
         cfg_ff.escalate_windows    <= RST_ESCALATE;
         cfg_ff.recover_windows     <= RST_RECOVER;
         cfg_ff.degrade_loss_tenths <= RST_DEGRADE_LOSS;
         cfg_ff.healthy_loss_tenths <= RST_HEALTHY_LOSS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;
   // write events go straight to the state, same edge as the register update
   assign evt = reset ? '0 : evt_in;

endmodule

// ===== rtl/lhfs_class.sv =====
// ----------------------------------------------------------------------------
// lhfs_class: window classifier
// Marks a window degraded or healthy from the loss registers and the fixed
// drop, retransmit and queue thresholds.
// ----------------------------------------------------------------------------
module lhfs_class (
   input  lhfs_pkg::req_item_type           item,
   input  logic [lhfs_pkg::LOSS_W-1:0]      degrade_loss_tenths,
   input  logic [lhfs_pkg::LOSS_W-1:0]      healthy_loss_tenths,
   output lhfs_pkg::class_type              win_class
);
   import lhfs_pkg::*;

   // any single bad sign degrades the window
   assign win_class.degraded = !item.sync_locked
                             || (item.loss_tenths       >= degrade_loss_tenths)
                             || (item.dropped_delta     >= DROP_DEGRADE_MIN)
                             || (item.retransmit_delta  >= RETX_DEGRADE_MIN)
                             || (item.video_queue_depth >= VQ_DEGRADE_MIN)
                             || (item.inflight_depth    >= INFL_DEGRADE_MIN);

   // healthy needs every sign clean
   assign win_class.healthy = item.sync_locked
                            && (item.loss_tenths       <= healthy_loss_tenths)
                            && (item.dropped_delta     == '0)
                            && (item.retransmit_delta  <= RETX_HEALTHY_MAX)
                            && (item.video_queue_depth <= VQ_HEALTHY_MAX)
                            && (item.inflight_depth    <= INFL_HEALTHY_MAX);

endmodule

// ===== rtl/lhfs_core.sv =====
// ----------------------------------------------------------------------------
// lhfs_core: stepper state and decision
// Rate-limits windows, updates the degraded and healthy runs and moves the
// stage up or down by one, spaced by the change interval.
// ----------------------------------------------------------------------------
module lhfs_core #(
   parameter int STAGE_COUNT = 5
) (
   input  logic                     clock,
   input  logic                     reset,
   input  lhfs_pkg::cfg_type        cfg,
   input  lhfs_pkg::csr_evt_type    evt,
   input  logic                     fire,
   input  lhfs_pkg::req_item_type   item,
   output lhfs_pkg::rsp_item_type   result
);
   import lhfs_pkg::*;

   localparam logic [STAGE_W-1:0] STAGE_MAX   = STAGE_W'(STAGE_COUNT - 1);
   localparam logic [STAGE_W-1:0] MAX_RESET   = stage_min(RST_MAX_STAGE, STAGE_MAX);
   localparam logic [STAGE_W-1:0] STAGE_RESET =
      stage_min(stage_min(RST_START_STAGE, STAGE_MAX), MAX_RESET);

   logic [STAGE_W-1:0] stage_ff, stage_in;
   logic [RUN_W-1:0]   deg_run_ff, deg_run_in;
   logic [RUN_W-1:0]   heal_run_ff, heal_run_in;
   logic               eval_seen_ff, eval_seen_in;
   logic [TIME_W-1:0]  last_eval_ff, last_eval_in;
   logic               change_seen_ff, change_seen_in;
   logic [TIME_W-1:0]  last_change_ff, last_change_in;

   class_type          win_class;
   logic [TIME_W-1:0]  eval_age;
   logic [TIME_W-1:0]  change_age;
   logic               rate_limited;
   logic               change_hold;
   logic [RUN_W-1:0]   deg_cnt;
   logic [RUN_W-1:0]   heal_cnt;
   logic               step_up;
   logic               step_down;

   lhfs_class u_class (
      .item                (item),
      .degrade_loss_tenths (cfg.degrade_loss_tenths),
      .healthy_loss_tenths (cfg.healthy_loss_tenths),
      .win_class           (win_class)
   );

   // time since last evaluated window and last stage change, modulo 2^40
   assign eval_age     = item.now_ms - last_eval_ff;
   assign change_age   = item.now_ms - last_change_ff;
   assign rate_limited = eval_seen_ff
                       && (eval_age < {{(TIME_W-CNT16_W){1'b0}}, cfg.eval_interval_ms});
   assign change_hold  = change_seen_ff
                       && (change_age < {{(TIME_W-CNT16_W){1'b0}}, cfg.change_interval_ms});

   // run counters after this window, saturating
   always_comb begin
      deg_cnt  = '0;
      heal_cnt = '0;
      if (win_class.degraded) begin
         deg_cnt = (deg_run_ff == RUN_SAT) ? RUN_SAT : deg_run_ff + 8'd1;
      end else if (win_class.healthy) begin
         heal_cnt = (heal_run_ff == RUN_SAT) ? RUN_SAT : heal_run_ff + 8'd1;
      end
   end

   // stage move: rising wins over falling
   assign step_up   = !change_hold && (deg_cnt >= cfg.escalate_windows)
                    && (stage_ff < cfg.max_stage);
   assign step_down = !change_hold && !step_up && (heal_cnt >= cfg.recover_windows)
                    && (stage_ff != '0);

   // next state and result
   always_comb begin
      stage_in       = stage_ff;
      deg_run_in     = deg_run_ff;
      heal_run_in    = heal_run_ff;
      eval_seen_in   = eval_seen_ff;
      last_eval_in   = last_eval_ff;
      change_seen_in = change_seen_ff;
      last_change_in = last_change_ff;

      result.changed       = 1'b0;
      result.evaluated     = 1'b0;
      result.current_stage = stage_ff;

      if (!rate_limited) begin
         result.evaluated = 1'b1;
         eval_seen_in     = 1'b1;
         last_eval_in     = item.now_ms;
         deg_run_in       = deg_cnt;
         heal_run_in      = heal_cnt;
         if (step_up || step_down) begin
            stage_in       = step_up ? stage_ff + 3'd1 : stage_ff - 3'd1;
            deg_run_in     = '0;
            heal_run_in    = '0;
            change_seen_in = 1'b1;
            last_change_in = item.now_ms;
            result.changed = 1'b1;
         end
         result.current_stage = stage_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff       <= STAGE_RESET;
         deg_run_ff     <= '0;
         heal_run_ff    <= '0;
         eval_seen_ff   <= 1'b0;
         last_eval_ff   <= '0;
         change_seen_ff <= 1'b0;
         last_change_ff <= '0;
      end else if (evt.start_wr) begin
         // controller restart from the newly written start stage
         stage_ff       <= evt.start_val;
         deg_run_ff     <= '0;
         heal_run_ff    <= '0;
         eval_seen_ff   <= 1'b0;
         last_eval_ff   <= '0;
         change_seen_ff <= 1'b0;
         last_change_ff <= '0;
      end else if (evt.max_wr) begin
         stage_ff <= stage_min(stage_ff, evt.max_val);
      end else if (fire) begin
         stage_ff       <= stage_in;
         deg_run_ff     <= deg_run_in;
         heal_run_ff    <= heal_run_in;
         eval_seen_ff   <= eval_seen_in;
         last_eval_ff   <= last_eval_in;
         change_seen_ff <= change_seen_in;
         last_change_ff <= last_change_in;
      end
   end

endmodule

// ===== rtl/link_health_fallback_stepper.sv =====
// ----------------------------------------------------------------------------
// link_health_fallback_stepper: link-health fallback stage controller
// Takes link-health windows and answers each with the fallback stage.
// ----------------------------------------------------------------------------
// One request beat in, one response beat out, in order. The block takes a beat
// every cycle unless the output register stalls; a beat waits in the input
// register, then the classifier, run counters and stage decision resolve in a
// single pass and the response lands in the output register. The stepper state
// is updated in that same pass, so the next window sees it at once. The output
// register stalls the pipe only while a response is held and its neighbor is
// not ready. Configuration writes take effect on the next edge and are meant
// for when no beat is in flight; a start_stage write restarts the controller.
module link_health_fallback_stepper #(
   parameter int STAGE_COUNT = 5
) (
   input  logic                              clock,
   input  logic                              reset,
   lhfs_req_if.sink                          req_ch,
   lhfs_rsp_if.source                        rsp_ch,
   input  logic                              csr_we,
   input  logic [lhfs_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [lhfs_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import lhfs_pkg::*;

   cfg_type       cfg;
   csr_evt_type   evt;

   logic          in_valid_ff, in_valid_in;
   req_item_type  in_item_ff, in_item_in;
   logic          out_valid_ff, out_valid_in;
   rsp_item_type  out_item_ff, out_item_in;
   rsp_item_type  result;
   logic          req_fire;
   logic          advance;
   logic          fire;

   lhfs_csr #(.STAGE_COUNT(STAGE_COUNT)) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg),
      .evt       (evt)
   );

   lhfs_core #(.STAGE_COUNT(STAGE_COUNT)) u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .evt    (evt),
      .fire   (fire),
      .item   (in_item_ff),
      .result (result)
   );

   // handshake: output register frees, input register follows
   assign advance      = !out_valid_ff || rsp_ch.ready;
   assign fire         = in_valid_ff && advance;
   assign req_ch.ready = !in_valid_ff || advance;
   assign req_fire     = req_ch.valid && req_ch.ready;

   always_comb begin
      in_valid_in  = req_fire || (in_valid_ff && !advance);
      out_valid_in = fire || (out_valid_ff && !rsp_ch.ready);

      in_item_in = in_item_ff;
      if (req_fire) begin
         in_item_in.sync_locked       = req_ch.sync_locked;
         in_item_in.loss_tenths       = req_ch.loss_tenths;
         in_item_in.dropped_delta     = req_ch.dropped_delta;
         in_item_in.retransmit_delta  = req_ch.retransmit_delta;
         in_item_in.video_queue_depth = req_ch.video_queue_depth;
         in_item_in.inflight_depth    = req_ch.inflight_depth;
         in_item_in.now_ms            = req_ch.now_ms;
      end

      out_item_in = fire ? result : out_item_ff;
   end

   // valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      in_item_ff  <= in_item_in;
      out_item_ff <= out_item_in;
   end

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.changed       = out_item_ff.changed;
   assign rsp_ch.current_stage = out_item_ff.current_stage;
   assign rsp_ch.evaluated     = out_item_ff.evaluated;

endmodule

// ===== rtl/lhfs_checker.sv =====
// ----------------------------------------------------------------------------
// lhfs_checker: port-level checks of the fallback stepper
// Watches the response channel for reset, range and consistency rules.
// ----------------------------------------------------------------------------
module lhfs_checker #(
   parameter int STAGE_COUNT = 5
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          rsp_changed,
   input logic [lhfs_pkg::STAGE_W-1:0]  rsp_current_stage,
   input logic                          rsp_evaluated
);
   import lhfs_pkg::*;

   localparam logic [STAGE_W-1:0] STAGE_MAX = STAGE_W'(STAGE_COUNT - 1);

   // no response beat right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // a rate-limited window never moves the stage
   a_skip_no_change: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_evaluated |-> !rsp_changed)
      else $error("stage changed on a window that was not evaluated");

   // stage stays within the configured stage count
   a_stage_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_current_stage <= STAGE_MAX)
      else $error("stage beyond the last stage");

   // a held response beat keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_changed)
         && $stable(rsp_current_stage) && $stable(rsp_evaluated))
      else $error("response beat dropped or changed while stalled");

endmodule

bind link_health_fallback_stepper lhfs_checker #(.STAGE_COUNT(STAGE_COUNT)) u_lhfs_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_changed       (rsp_ch.changed),
   .rsp_current_stage (rsp_ch.current_stage),
   .rsp_evaluated     (rsp_ch.evaluated)
);

// ===== test/link_health_fallback_stepper_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// link_health_fallback_stepper_tb: self-checking bench for the fallback stepper
// Directed windows from a table, forced run-counter saturation, then random
// phases of register settings and class-biased windows. Each response beat is
// compared against the table's expected value or an in-bench model of the stage controller.
// ----------------------------------------------------------------------------
module link_health_fallback_stepper_tb;
   import lhfs_pkg::*;

   localparam int STAGE_COUNT   = 5;
   localparam logic [STAGE_W-1:0] STAGE_TOP = STAGE_W'(STAGE_COUNT - 1);
   localparam int ITEM_TARGET   = 1450;
   localparam int CALM_TAIL     = 200;
   localparam int PHASE_WINDOWS = 90;
   localparam int SAT_WINDOWS   = 260;
   localparam int CYCLE_LIMIT   = 600000;

   // fixed class thresholds
   localparam int DROP_BAD  = 2;
   localparam int RETX_BAD  = 3;
   localparam int VQ_BAD    = 32;
   localparam int INFL_BAD  = 24;
   localparam int RETX_GOOD = 1;
   localparam int VQ_GOOD   = 8;
   localparam int INFL_GOOD = 6;
   localparam logic [RUN_W-1:0] RUN_CAP = 8'hFF;

   typedef enum logic [1:0] {WIN_BAD, WIN_GOOD, WIN_MIXED, WIN_NOISE} window_kind_type;

   typedef struct packed {
      req_item_type win;
      logic         typed;
      rsp_item_type want;
   } probe_row_type;

   // sync, loss, dropped, retx, vqueue, inflight, now | typed | changed, stage, evaluated
   localparam probe_row_type PROBES [20] = '{
      // first window after reset is always counted
      {1'b1, 10'd0,    16'd0,     16'd0,     16'd0,     16'd0,     40'd0,
       1'b1, 1'b0, 3'd0, 1'b1},
      // too soon after the last counted window
      {1'b1, 10'd0,    16'd0,     16'd0,     16'd0,     16'd0,     40'd500,
       1'b1, 1'b0, 3'd0, 1'b0},
      // one degraded cause per window, third one raises the stage
      {1'b0, 10'd0,    16'd0,     16'd0,     16'd0,     16'd0,     40'd1000,
       1'b1, 1'b0, 3'd0, 1'b1},
      {1'b1, 10'd180,  16'd0,     16'd0,     16'd0,     16'd0,     40'd2000,
       1'b1, 1'b0, 3'd0, 1'b1},
      {1'b1, 10'd0,    16'd2,     16'd0,     16'd0,     16'd0,     40'd3000,
       1'b1, 1'b1, 3'd1, 1'b1},
      {1'b1, 10'd0,    16'd0,     16'd3,     16'd0,     16'd0,     40'd4000,
       1'b1, 1'b0, 3'd1, 1'b1},
      {1'b1, 10'd0,    16'd0,     16'd0,     16'd32,    16'd0,     40'd5000,
       1'b1, 1'b0, 3'd1, 1'b1},
      // run is long enough, but the change spacing holds it
      {1'b1, 10'd0,    16'd0,     16'd0,     16'd0,     16'd24,    40'd6000,
       1'b1, 1'b0, 3'd1, 1'b1},
      // every field at its top value
      {1'b0, 10'd1023, 16'd65535, 16'd65535, 16'd65535, 16'd65535, 40'd7000,
       1'b1, 1'b0, 3'd1, 1'b1},
      // neither class: runs cleared
      {1'b1, 10'd51,   16'd0,     16'd0,     16'd0,     16'd0,     40'd8000,
       1'b1, 1'b0, 3'd1, 1'b1},
      {1'b1, 10'd0,    16'd0,     16'd2,     16'd0,     16'd0,     40'd9000,
       1'b1, 1'b0, 3'd1, 1'b1},
      {1'b1, 10'd0,    16'd0,     16'd0,     16'd0,     16'd0,     40'd9999,
       1'b1, 1'b0, 3'd1, 1'b0},
      {1'b1, 10'd0,    16'd0,     16'd0,     16'd9,     16'd0,     40'd10000,
       1'b1, 1'b0, 3'd1, 1'b1},
      {1'b1, 10'd0,    16'd1,     16'd0,     16'd0,     16'd7,     40'd11000,
       1'b1, 1'b0, 3'd1, 1'b1},
      // just under every degraded threshold, then exactly at the healthy limits
      {1'b1, 10'd179,  16'd1,     16'd2,     16'd31,    16'd23,    40'd12000,
       1'b0, 1'b0, 3'd0, 1'b0},
      {1'b1, 10'd50,   16'd0,     16'd1,     16'd8,     16'd6,     40'd13000,
       1'b0, 1'b0, 3'd0, 1'b0},
      // timestamp wrap: near the top, then small values past zero
      {1'b1, 10'd0,    16'd0,     16'd0,     16'd0,     16'd0,     40'hFF_FFFF_FF00,
       1'b0, 1'b0, 3'd0, 1'b0},
      {1'b1, 10'd0,    16'd0,     16'd0,     16'd0,     16'd0,     40'h00_0000_0100,
       1'b0, 1'b0, 3'd0, 1'b0},
      {1'b1, 10'd0,    16'd0,     16'd0,     16'd0,     16'd0,     40'h00_0000_0500,
       1'b0, 1'b0, 3'd0, 1'b0},
      // time going backwards
      {1'b1, 10'd0,    16'd0,     16'd0,     16'd0,     16'd0,     40'h00_0000_0400,
       1'b0, 1'b0, 3'd0, 1'b0}
   };

   logic clock;
   logic reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   lhfs_req_if req_ch ();
   lhfs_rsp_if rsp_ch ();

   link_health_fallback_stepper #(
      .STAGE_COUNT(STAGE_COUNT)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .rsp_ch   (rsp_ch),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // model registers and controller state
   logic [STAGE_W-1:0]  lim_stage, boot_stage, cur_stage;
   logic [CNT16_W-1:0]  eval_gap_ms, change_gap_ms;
   logic [RUN_W-1:0]    rise_after, fall_after, bad_run, good_run;
   logic [LOSS_W-1:0]   bad_loss, good_loss;
   logic                evaluated_once, changed_once;
   logic [TIME_W-1:0]   last_eval_ms, last_change_ms;

   rsp_item_type stage_expect [$];

   int err_count         = 0;
   int windows_sent      = 0;
   int windows_evaluated = 0;
   int moves_seen        = 0;
   int settings_done     = 0;
   int cycle_count       = 0;
   logic gappy           = 1'b1;
   logic stalls_on       = 1'b1;
   logic calm            = 1'b0;
   logic [TIME_W-1:0] wall_ms;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic [STAGE_W-1:0] clamp_top(input logic [STAGE_W-1:0] v);
      return (v > STAGE_TOP) ? STAGE_TOP : v;
   endfunction

   // start_stage write and reset both restart the controller
   function automatic void restart_controller();
      cur_stage = clamp_top(boot_stage);
      if (cur_stage > lim_stage)
         cur_stage = lim_stage;
      bad_run        = '0;
      good_run       = '0;
      evaluated_once = 1'b0;
      last_eval_ms   = '0;
      changed_once   = 1'b0;
      last_change_ms = '0;
   endfunction

   function automatic void mirror_csr(input csr_index_type idx,
                                      input logic [CSR_DATA_W-1:0] d);
      case (idx)
         CSR_MAX_STAGE: begin
            lim_stage = clamp_top(d[STAGE_W-1:0]);
            if (cur_stage > lim_stage)
               cur_stage = lim_stage;
         end
         CSR_START_STAGE: begin
            boot_stage = d[STAGE_W-1:0];
            restart_controller();
         end
         CSR_EVAL_INTERVAL:   eval_gap_ms   = d;
         CSR_CHANGE_INTERVAL: change_gap_ms = d;
         CSR_ESCALATE:        rise_after    = d[RUN_W-1:0];
         CSR_RECOVER:         fall_after    = d[RUN_W-1:0];
         CSR_DEGRADE_LOSS:    bad_loss      = d[LOSS_W-1:0];
         CSR_HEALTHY_LOSS:    good_loss     = d[LOSS_W-1:0];
         default: ;
      endcase
   endfunction

   // next stage response for one window; updates the controller state
   function automatic rsp_item_type predict_stage(input req_item_type w);
      rsp_item_type r;
      logic [TIME_W-1:0] since_eval, since_change;
      logic bad, good;
      r.changed   = 1'b0;
      r.evaluated = 1'b0;
      since_eval  = w.now_ms - last_eval_ms;
      if (evaluated_once && since_eval < TIME_W'(eval_gap_ms)) begin
         r.current_stage = cur_stage;
         return r;
      end
      evaluated_once = 1'b1;
      last_eval_ms   = w.now_ms;
      r.evaluated    = 1'b1;

      bad  = !w.sync_locked || w.loss_tenths >= bad_loss || w.dropped_delta >= DROP_BAD ||
             w.retransmit_delta >= RETX_BAD || w.video_queue_depth >= VQ_BAD ||
             w.inflight_depth >= INFL_BAD;
      good = w.sync_locked && w.loss_tenths <= good_loss && w.dropped_delta == 0 &&
             w.retransmit_delta <= RETX_GOOD && w.video_queue_depth <= VQ_GOOD &&
             w.inflight_depth <= INFL_GOOD;

      // saturating run counters
      if (bad) begin
         bad_run  = (bad_run == RUN_CAP) ? RUN_CAP : bad_run + 8'd1;
         good_run = '0;
      end else if (good) begin
         good_run = (good_run == RUN_CAP) ? RUN_CAP : good_run + 8'd1;
         bad_run  = '0;
      end else begin
         bad_run  = '0;
         good_run = '0;
      end

      // stage step, spaced by the change interval
      since_change = w.now_ms - last_change_ms;
      if (!(changed_once && since_change < TIME_W'(change_gap_ms))) begin
         if (bad_run >= rise_after && cur_stage < lim_stage) begin
            cur_stage = clamp_top(cur_stage + 3'd1);
            r.changed = 1'b1;
         end else if (good_run >= fall_after && cur_stage > 0) begin
            cur_stage = cur_stage - 3'd1;
            r.changed = 1'b1;
         end
         if (r.changed) begin
            bad_run        = '0;
            good_run       = '0;
            changed_once   = 1'b1;
            last_change_ms = w.now_ms;
         end
      end
      r.current_stage = cur_stage;
      return r;
   endfunction

   // random window of the given kind; all but noise follow the current loss limits
   function automatic req_item_type shape_window(input window_kind_type kind,
                                                 input logic [TIME_W-1:0] now);
      req_item_type w;
      w.sync_locked       = 1'b1;
      w.loss_tenths       = LOSS_W'($urandom_range(0, good_loss));
      w.dropped_delta     = '0;
      w.retransmit_delta  = CNT16_W'($urandom_range(0, RETX_GOOD));
      w.video_queue_depth = CNT16_W'($urandom_range(0, VQ_GOOD));
      w.inflight_depth    = CNT16_W'($urandom_range(0, INFL_GOOD));
      case (kind)
         WIN_BAD: begin
            case ($urandom_range(0, 5))
               0: w.sync_locked = 1'b0;
               1: w.loss_tenths = LOSS_W'($urandom_range(bad_loss, 1023));
               2: w.dropped_delta = CNT16_W'($urandom_range(0, 1) ?
                     $urandom_range(DROP_BAD, 5) : $urandom_range(DROP_BAD, 65535));
               3: w.retransmit_delta = CNT16_W'($urandom_range(0, 1) ?
                     $urandom_range(RETX_BAD, 6) : $urandom_range(RETX_BAD, 65535));
               4: w.video_queue_depth = CNT16_W'($urandom_range(0, 1) ?
                     $urandom_range(VQ_BAD, 40) : $urandom_range(VQ_BAD, 65535));
               default: w.inflight_depth = CNT16_W'($urandom_range(0, 1) ?
                     $urandom_range(INFL_BAD, 30) : $urandom_range(INFL_BAD, 65535));
            endcase
         end
         WIN_MIXED: begin
            case ($urandom_range(0, 4))
               0: w.loss_tenths = LOSS_W'($urandom_range(good_loss + 1, bad_loss));
               1: w.dropped_delta = 16'd1;
               2: w.retransmit_delta = 16'd2;
               3: w.video_queue_depth = CNT16_W'($urandom_range(VQ_GOOD + 1, VQ_BAD - 1));
               default: w.inflight_depth =
                  CNT16_W'($urandom_range(INFL_GOOD + 1, INFL_BAD - 1));
            endcase
         end
         WIN_NOISE: begin
            w.sync_locked       = 1'($urandom);
            w.loss_tenths       = LOSS_W'($urandom);
            w.dropped_delta     = CNT16_W'($urandom);
            w.retransmit_delta  = CNT16_W'($urandom);
            w.video_queue_depth = CNT16_W'($urandom);
            w.inflight_depth    = CNT16_W'($urandom);
         end
         default: ;
      endcase
      w.now_ms = now;
      return w;
   endfunction

   // register value with random bits above its width
   function automatic logic [CSR_DATA_W-1:0] junk_above(input logic [CSR_DATA_W-1:0] v,
                                                        input int w);
      logic [CSR_DATA_W-1:0] keep;
      keep = (CSR_DATA_W'(1) << w) - CSR_DATA_W'(1);
      return (CSR_DATA_W'($urandom) & ~keep) | (v & keep);
   endfunction

   // one window beat, with an optional gap in front
   task automatic send_window(input req_item_type w, input logic typed,
                              input rsp_item_type want);
      rsp_item_type model_rsp;
      if (gappy && !calm && $urandom_range(0, 5) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_ch.valid             <= 1'b1;
      req_ch.sync_locked       <= w.sync_locked;
      req_ch.loss_tenths       <= w.loss_tenths;
      req_ch.dropped_delta     <= w.dropped_delta;
      req_ch.retransmit_delta  <= w.retransmit_delta;
      req_ch.video_queue_depth <= w.video_queue_depth;
      req_ch.inflight_depth    <= w.inflight_depth;
      req_ch.now_ms            <= w.now_ms;
      do @(posedge clock); while (!req_ch.ready);
      model_rsp = predict_stage(w);
      stage_expect.push_back(typed ? want : model_rsp);
      windows_sent++;
      if (model_rsp.evaluated)
         windows_evaluated++;
   endtask

   // hold off until every expected beat is back and the pipe is empty
   task automatic drain();
      req_ch.valid <= 1'b0;
      while (stage_expect.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] d);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= d;
      @(posedge clock);
      mirror_csr(idx, d);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // extremes for the first two phases, random settings after
   task automatic program_settings(input int p);
      logic [CSR_DATA_W-1:0] vmax, vstart, veval, vchg, vesc, vrec, vdeg, vhl;
      if (p == 0) begin
         vmax = 16'd7;  vstart = 16'd7;  veval = 16'd0;    vchg = 16'd0;
         vesc = 16'd0;  vrec = 16'd0;    vdeg = 16'd1023;  vhl = 16'd1023;
      end else if (p == 1) begin
         vmax = 16'd0;    vstart = 16'd0;    veval = 16'd65535; vchg = 16'd65535;
         vesc = 16'd255;  vrec = 16'd255;    vdeg = 16'd0;      vhl = 16'd0;
      end else begin
         vmax   = CSR_DATA_W'($urandom_range(0, 7));
         vstart = CSR_DATA_W'($urandom_range(0, 7));
         case ($urandom_range(0, 5))
            0:       veval = 16'd0;
            1:       veval = 16'd65535;
            2:       veval = CSR_DATA_W'($urandom);
            default: veval = CSR_DATA_W'($urandom_range(1, 40));
         endcase
         case ($urandom_range(0, 5))
            0:       vchg = 16'd0;
            1:       vchg = 16'd65535;
            2:       vchg = CSR_DATA_W'($urandom);
            default: vchg = CSR_DATA_W'($urandom_range(1, 200));
         endcase
         case ($urandom_range(0, 7))
            0:       vesc = 16'd0;
            1:       vesc = 16'd255;
            default: vesc = CSR_DATA_W'($urandom_range(1, 6));
         endcase
         case ($urandom_range(0, 7))
            0:       vrec = 16'd0;
            1:       vrec = 16'd255;
            default: vrec = CSR_DATA_W'($urandom_range(1, 20));
         endcase
         case ($urandom_range(0, 5))
            0:       vdeg = 16'd0;
            1:       vdeg = 16'd1023;
            default: vdeg = CSR_DATA_W'($urandom_range(60, 400));
         endcase
         case ($urandom_range(0, 5))
            0:       vhl = 16'd0;
            1:       vhl = 16'd1023;
            default: vhl = CSR_DATA_W'($urandom_range(0, 120));
         endcase
      end
      write_csr(CSR_MAX_STAGE,       junk_above(vmax, STAGE_W));
      write_csr(CSR_START_STAGE,     junk_above(vstart, STAGE_W));
      write_csr(CSR_EVAL_INTERVAL,   veval);
      write_csr(CSR_CHANGE_INTERVAL, vchg);
      write_csr(CSR_ESCALATE,        junk_above(vesc, RUN_W));
      write_csr(CSR_RECOVER,         junk_above(vrec, RUN_W));
      write_csr(CSR_DEGRADE_LOSS,    junk_above(vdeg, LOSS_W));
      write_csr(CSR_HEALTHY_LOSS,    junk_above(vhl, LOSS_W));
      // a late max_stage write clamps the running stage
      if (p > 1 && $urandom_range(0, 1))
         write_csr(CSR_MAX_STAGE, CSR_DATA_W'($urandom));
      settings_done++;
   endtask

   // Drive both run counters into saturation while the change spacing blocks
   // every step after the first, then raise the window count to 255 so only a
   // saturated run can move the stage.
   task automatic drive_run_saturation();
      logic [TIME_W-1:0] t0;
      window_kind_type kind;
      int pass_no;
      int i;
      for (pass_no = 0; pass_no < 2; pass_no++) begin
         kind = (pass_no == 0) ? WIN_BAD : WIN_GOOD;
         gappy     = 1'($urandom);
         stalls_on = 1'($urandom);
         drain();
         write_csr(CSR_MAX_STAGE,       16'd4);
         write_csr(CSR_EVAL_INTERVAL,   16'd0);
         write_csr(CSR_CHANGE_INTERVAL, 16'd65535);
         write_csr(CSR_ESCALATE,        (kind == WIN_BAD) ? 16'd1 : 16'd255);
         write_csr(CSR_RECOVER,         (kind == WIN_BAD) ? 16'd255 : 16'd1);
         write_csr(CSR_DEGRADE_LOSS,    16'd180);
         write_csr(CSR_HEALTHY_LOSS,    16'd50);
         write_csr(CSR_START_STAGE,     (kind == WIN_BAD) ? 16'd0 : 16'd4);
         t0 = {8'($urandom), 32'($urandom)};
         for (i = 0; i <= SAT_WINDOWS; i++)
            send_window(shape_window(kind, t0 + TIME_W'(i)), 1'b0, '0);
         drain();
         if (kind == WIN_BAD)
            write_csr(CSR_ESCALATE, 16'd255);
         else
            write_csr(CSR_RECOVER, 16'd255);
         send_window(shape_window(kind, t0 + 40'd70000), 1'b0, '0);
         settings_done++;
      end
   endtask

   // class bursts with timestamps spread around the two intervals
   task automatic run_mixed_phase();
      int start_eval;
      int burst_left;
      int n;
      int pick;
      window_kind_type kind;
      start_eval = windows_evaluated;
      burst_left = 0;
      n          = 0;
      kind       = WIN_GOOD;
      gappy      = $urandom_range(0, 3) != 0;
      stalls_on  = $urandom_range(0, 3) != 0;
      if ($urandom_range(0, 3) == 0)
         wall_ms = '1 - TIME_W'($urandom_range(0, 5000));
      else
         wall_ms = {8'($urandom), 32'($urandom)};
      while (windows_evaluated - start_eval < PHASE_WINDOWS &&
             windows_sent < ITEM_TARGET) begin
         calm = windows_sent >= ITEM_TARGET - CALM_TAIL;
         if (burst_left == 0) begin
            pick = $urandom_range(0, 99);
            if (pick < 40)      kind = WIN_BAD;
            else if (pick < 80) kind = WIN_GOOD;
            else if (pick < 92) kind = WIN_MIXED;
            else                kind = WIN_NOISE;
            burst_left = $urandom_range(1, 24);
         end
         pick = $urandom_range(0, 19);
         if (pick <= 12)
            wall_ms = wall_ms + TIME_W'(eval_gap_ms) +
                      TIME_W'($urandom_range(0, eval_gap_ms / 4 + 3));
         else if (pick <= 16)
            wall_ms = wall_ms + TIME_W'($urandom_range(0, eval_gap_ms));
         else if (pick <= 18)
            wall_ms = wall_ms + TIME_W'(change_gap_ms) + TIME_W'($urandom_range(0, 3));
         else
            wall_ms = {8'($urandom), 32'($urandom)};
         n++;
         if (n == 40)
            drain();
         send_window(shape_window(kind, wall_ms), 1'b0, '0);
         burst_left--;
      end
   endtask

   // response side: ready with random stall bursts
   initial begin
      rsp_ch.ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (stalls_on && !calm && $urandom_range(0, 7) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // compare each response beat with the oldest expectation
   always @(posedge clock) begin : check_beats
      rsp_item_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (stage_expect.size() == 0) begin
            err_count++;
            $display("%0t: unexpected beat: expected none, got changed=%0d stage=%0d evaluated=%0d",
                     $time, rsp_ch.changed, rsp_ch.current_stage, rsp_ch.evaluated);
         end else begin
            want = stage_expect.pop_front();
            if (rsp_ch.changed) moves_seen++;
            if (rsp_ch.changed !== want.changed ||
                rsp_ch.current_stage !== want.current_stage ||
                rsp_ch.evaluated !== want.evaluated) begin
               err_count++;
               if (rsp_ch.changed !== want.changed)
                  $display("%0t: changed: expected %0d, got %0d",
                           $time, want.changed, rsp_ch.changed);
               if (rsp_ch.current_stage !== want.current_stage)
                  $display("%0t: current_stage: expected %0d, got %0d",
                           $time, want.current_stage, rsp_ch.current_stage);
               if (rsp_ch.evaluated !== want.evaluated)
                  $display("%0t: evaluated: expected %0d, got %0d",
                           $time, want.evaluated, rsp_ch.evaluated);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      int phase;
      reset                    <= 1'b1;
      req_ch.valid             <= 1'b0;
      req_ch.sync_locked       <= 1'b0;
      req_ch.loss_tenths       <= '0;
      req_ch.dropped_delta     <= '0;
      req_ch.retransmit_delta  <= '0;
      req_ch.video_queue_depth <= '0;
      req_ch.inflight_depth    <= '0;
      req_ch.now_ms            <= '0;
      csr_we                   <= 1'b0;
      csr_index                <= CSR_MAX_STAGE;
      csr_wdata                <= '0;

      // register values after reset
      lim_stage     = clamp_top(3'd4);
      boot_stage    = 3'd0;
      eval_gap_ms   = 16'd1000;
      change_gap_ms = 16'd5000;
      rise_after    = 8'd3;
      fall_after    = 8'd15;
      bad_loss      = 10'd180;
      good_loss     = 10'd50;
      restart_controller();

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (PROBES[k])
         send_window(PROBES[k].win, PROBES[k].typed, PROBES[k].want);

      drive_run_saturation();

      phase = 0;
      while (windows_sent < ITEM_TARGET) begin
         drain();
         program_settings(phase);
         run_mixed_phase();
         phase++;
      end

      req_ch.valid <= 1'b0;
      while (stage_expect.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("covered %0d windows (%0d counted), %0d stage steps, %0d register settings",
               windows_sent, windows_evaluated, moves_seen, settings_done);
      $display("incl. both run counters saturated, timestamp wrap and extreme limits");
      if (err_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/lhfs_pkg.sv
rtl/lhfs_if.sv
rtl/lhfs_csr.sv
rtl/lhfs_class.sv
rtl/lhfs_core.sv
rtl/link_health_fallback_stepper.sv
rtl/lhfs_checker.sv
test/link_health_fallback_stepper_tb.sv
